@@ hw/rtl/rcfs_pkg.sv @@
// Shared types and constants for the receiver frame decoder.
// Holds frame codes, fixed-point map coefficients and the stage struct.
// No dependencies.
package rcfs_pkg;

  localparam int FRAME_BYTES = 16;
  localparam int CNT_W       = 5;
  localparam int CH_W        = 11;
  localparam int REF_W       = 21;
  localparam int SLOPE_W     = 27;
  localparam int DELTA_W     = 12;
  localparam int PROD_W      = DELTA_W + SLOPE_W;
  localparam int SUM_W       = 24;
  localparam int HOLD_W      = 64;
  localparam int TDATA_W     = 96;

  localparam logic [7:0] TYPE_ATT  = 8'h54;
  localparam logic [7:0] TYPE_YAW  = 8'h5C;
  localparam logic [7:0] SYNC_HEAD = 8'h00;
  localparam logic [7:0] SYNC_TAIL = 8'hFF;
  localparam logic [7:0] CH_HI_MASK = 8'h07;

  localparam logic KIND_ATT = 1'b0;
  localparam logic KIND_YAW = 1'b1;

  localparam logic signed [DELTA_W-1:0] CH_LOW = 12'sd343;
  localparam logic signed [PROD_W-1:0]  ROUND_HALF = 39'sd32768;
  localparam logic signed [SUM_W-1:0]   OUT_MAX = 24'sd1048575;
  localparam logic signed [SUM_W-1:0]   OUT_MIN = -24'sd1048576;

  // Coefficients worked out exactly at elaboration: round(a * 2^s / b), ties up.
  localparam logic [127:0] UNIT = 128'd100000000000;
  localparam logic [127:0] DEG  = 128'd1745329252;
  localparam logic [127:0] SPAN = 128'd1362;

  localparam logic [127:0] ROLL_BASE_Q  = (((20 * DEG) << 17) + UNIT) / (2 * UNIT);
  localparam logic [127:0] THR_BASE_Q   = (((2 * UNIT) << 17) + UNIT) / (2 * UNIT);
  localparam logic [127:0] YAW_BASE_Q   = (((180 * DEG) << 17) + UNIT) / (2 * UNIT);
  localparam logic [127:0] ROLL_SLOPE_Q =
    (((40 * DEG) << 33) + UNIT * SPAN) / (2 * UNIT * SPAN);
  localparam logic [127:0] THR_SLOPE_Q  =
    (((8 * UNIT) << 33) + UNIT * SPAN) / (2 * UNIT * SPAN);
  localparam logic [127:0] YAW_SLOPE_Q  =
    (((360 * DEG) << 33) + UNIT * SPAN) / (2 * UNIT * SPAN);

  localparam logic signed [REF_W-1:0]   ROLL_BASE  = REF_W'(ROLL_BASE_Q);
  localparam logic signed [REF_W-1:0]   THR_BASE   = REF_W'(THR_BASE_Q);
  localparam logic signed [REF_W-1:0]   YAW_BASE   = REF_W'(YAW_BASE_Q);
  // Roll, pitch and yaw fall across the stick range: negative slopes.
  localparam logic signed [SLOPE_W-1:0] ROLL_SLOPE = SLOPE_W'(128'd0 - ROLL_SLOPE_Q);
  localparam logic signed [SLOPE_W-1:0] THR_SLOPE  = SLOPE_W'(THR_SLOPE_Q);
  localparam logic signed [SLOPE_W-1:0] YAW_SLOPE  = SLOPE_W'(128'd0 - YAW_SLOPE_Q);

  typedef struct packed {
    logic            valid;
    logic            kind;
    logic [CH_W-1:0] ch_a;
    logic [CH_W-1:0] ch_b;
    logic [CH_W-1:0] ch_c;
  } frame_t;

endpackage

@@ hw/rtl/rcfs_window.sv @@
// Byte window, byte counter and frame sync detection.
// Flags a frame of known type on the beat of its closing byte.
// Depends on rcfs_pkg.
module rcfs_window
  import rcfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output frame_t     frame
);

  // Newest FRAME_BYTES-1 bytes; win[FRAME_BYTES-2] is the newest.
  logic [7:0]       win [FRAME_BYTES-1];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] count_next;
  logic             sync;
  logic [7:0]       type_code;

  assign count_inc = (count < CNT_W'(FRAME_BYTES)) ? count + CNT_W'(1) : count;

  // Window after this beat: entry k is win[k], entry FRAME_BYTES-1 is rx_byte.
  assign sync = (count_inc == CNT_W'(FRAME_BYTES)) &&
                (win[0] == SYNC_HEAD) && (win[1] == SYNC_HEAD) &&
                (win[FRAME_BYTES-2] == SYNC_TAIL) && (rx_byte == SYNC_TAIL);
  assign count_next = sync ? '0 : count_inc;
  assign type_code = win[12];

  always_comb begin
    frame.valid = accept && sync &&
                  ((type_code == TYPE_ATT) || (type_code == TYPE_YAW));
    frame.kind  = (type_code == TYPE_YAW) ? KIND_YAW : KIND_ATT;
    frame.ch_a  = {win[2][2:0] & CH_HI_MASK[2:0], win[3]};
    frame.ch_b  = {win[4][2:0] & CH_HI_MASK[2:0], win[5]};
    frame.ch_c  = {win[6][2:0] & CH_HI_MASK[2:0], win[7]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int i = 0; i < FRAME_BYTES - 1; i++) begin
        win[i] <= '0;
      end
    end else if (accept) begin
      count <= count_next;
      for (int i = 0; i < FRAME_BYTES - 2; i++) begin
        win[i] <= win[i+1];
      end
      win[FRAME_BYTES-2] <= rx_byte;
    end
  end

  a_sync_clears_count: assert property (@(posedge clk) disable iff (rst)
    (accept && sync) |=> (count == '0))
    else $error("byte count not cleared after frame");

  a_frame_needs_full_window: assert property (@(posedge clk) disable iff (rst)
    frame.valid |-> (count >= CNT_W'(FRAME_BYTES - 1)))
    else $error("frame flagged before a full window");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FRAME_BYTES))
    else $error("byte count past window size");

endmodule

@@ hw/rtl/rcfs_map.sv @@
// Linear channel map: product stage, then round, offset and saturate.
// Product register advances with the decoder pipeline.
// Depends on rcfs_pkg.
module rcfs_map
  import rcfs_pkg::*;
(
  input  logic                      clk,
  input  logic                      adv,
  input  logic [CH_W-1:0]           chan,
  input  logic signed [SLOPE_W-1:0] slope,
  input  logic signed [REF_W-1:0]   base,
  output logic signed [REF_W-1:0]   map_out
);

  logic signed [DELTA_W-1:0]  delta;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   rsum;
  logic signed [PROD_W-17:0]  quot;
  logic signed [SUM_W-1:0]    total;

  assign delta = $signed({1'b0, chan}) - CH_LOW;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= delta * slope;
    end
  end

  // Round to Q16: add half, floor by arithmetic shift.
  assign rsum  = prod + ROUND_HALF;
  assign quot  = $signed(rsum[PROD_W-1:16]);
  assign total = SUM_W'(quot) + SUM_W'(base);

  always_comb begin
    if (total > OUT_MAX) begin
      map_out = REF_W'(OUT_MAX);
    end else if (total < OUT_MIN) begin
      map_out = REF_W'(OUT_MIN);
    end else begin
      map_out = REF_W'(total);
    end
  end

endmodule

@@ hw/rtl/rcfs_hold_mem.sv @@
// Two-entry hold memory: one word per frame kind, registered read.
// Entries read as zero until first written.
// Depends on rcfs_pkg.
module rcfs_hold_mem
  import rcfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic              rd_addr,
  input  logic              wr_en,
  input  logic              wr_addr,
  input  logic [HOLD_W-1:0] wr_data,
  output logic [HOLD_W-1:0] rd_data
);

  logic [HOLD_W-1:0] mem [2];
  logic [1:0]        filled;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (wr_en) begin
      filled[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= filled[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

@@ hw/rtl/rc_frame_sync_channel_map_top.sv @@
// Receiver frame decoder top level: window, channel maps, hold memory, output.
// Depends on rcfs_pkg, rcfs_window, rcfs_map, rcfs_hold_mem.
//
// One receiver byte is taken per clock cycle on s_axis. A 16-byte frame with
// 0x00 0x00 head and 0xFF 0xFF tail, type 0x54 or 0x5C, yields one result
// beat on m_axis via s1, s2 and the output register; other bytes yield
// nothing. Each result carries all held references (roll, pitch, throttle,
// yaw in signed Q4.16) and the raw toggle channel; tuser flags which frame
// kind was updated. The path is: detect in the byte window, multiply in the
// three channel maps while the hold memory reads the word of the other kind,
// then round, saturate and write back. s_axis_tready drops only while a
// result waits in the output register and the next one is ready to leave.
module rc_frame_sync_channel_map_top
  import rcfs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // rx_byte[7:0]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // roll_ref[20:0], pitch_ref[41:21], throttle_ref[62:42], yaw_ref[83:63],
  // toggle_value[94:84], zero pad[95]
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic [0:0]         m_axis_tuser    // frame_kind[0]
);

  frame_t det;
  frame_t s1;
  frame_t s2;

  logic accept;
  logic s2_stall;
  logic adv;
  logic s2_fire;

  logic signed [REF_W-1:0]   map_a;
  logic signed [REF_W-1:0]   map_b;
  logic signed [REF_W-1:0]   map_c;
  logic signed [SLOPE_W-1:0] slope_c;
  logic signed [REF_W-1:0]   base_c;

  logic [HOLD_W-1:0] rd_word;
  logic [HOLD_W-1:0] wr_word;

  logic [REF_W-1:0] roll_next;
  logic [REF_W-1:0] pitch_next;
  logic [REF_W-1:0] throttle_next;
  logic [REF_W-1:0] yaw_next;
  logic [CH_W-1:0]  toggle_next;

  logic             out_valid;
  logic             out_kind;
  logic [REF_W-1:0] out_roll;
  logic [REF_W-1:0] out_pitch;
  logic [REF_W-1:0] out_throttle;
  logic [REF_W-1:0] out_yaw;
  logic [CH_W-1:0]  out_toggle;

  assign s2_stall      = s2.valid && out_valid && !m_axis_tready;
  assign adv           = !s2_stall;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s2_fire       = s2.valid && !s2_stall;

  rcfs_window u_window (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (s_axis_tdata),
    .frame   (det)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
    end else if (adv) begin
      s1 <= det;
      s2 <= s1;
    end
  end

  // Slope follows the frame in stage one, offset the frame in stage two.
  assign slope_c = (s1.kind == KIND_YAW) ? YAW_SLOPE : ROLL_SLOPE;
  assign base_c  = (s2.kind == KIND_YAW) ? YAW_BASE : ROLL_BASE;

  rcfs_map u_map_a (
    .clk (clk), .adv (adv), .chan (s1.ch_a),
    .slope (ROLL_SLOPE), .base (ROLL_BASE), .map_out (map_a)
  );

  rcfs_map u_map_b (
    .clk (clk), .adv (adv), .chan (s1.ch_b),
    .slope (THR_SLOPE), .base (THR_BASE), .map_out (map_b)
  );

  rcfs_map u_map_c (
    .clk (clk), .adv (adv), .chan (s1.ch_c),
    .slope (slope_c), .base (base_c), .map_out (map_c)
  );

  // Read the word of the other kind; frames are a full window apart, so a
  // read never meets a write to the same entry in flight.
  rcfs_hold_mem u_hold (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (adv),
    .rd_addr (~s1.kind),
    .wr_en   (s2_fire),
    .wr_addr (s2.kind),
    .wr_data (wr_word),
    .rd_data (rd_word)
  );

  always_comb begin
    roll_next     = rd_word[REF_W-1:0];
    pitch_next    = rd_word[2*REF_W-1:REF_W];
    throttle_next = rd_word[3*REF_W-1:2*REF_W];
    yaw_next      = rd_word[REF_W-1:0];
    toggle_next   = rd_word[REF_W+CH_W-1:REF_W];
    wr_word       = '0;
    case (s2.kind)
      KIND_ATT: begin
        roll_next     = map_a;
        throttle_next = map_b;
        pitch_next    = map_c;
        wr_word       = HOLD_W'({throttle_next, pitch_next, roll_next});
      end
      KIND_YAW: begin
        roll_next     = rd_word[REF_W-1:0];
        yaw_next      = map_c;
        toggle_next   = s2.ch_a;
        wr_word       = HOLD_W'({toggle_next, yaw_next});
      end
      default: begin
        wr_word = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_kind     <= s2.kind;
      out_roll     <= roll_next;
      out_pitch    <= pitch_next;
      out_throttle <= throttle_next;
      out_yaw      <= yaw_next;
      out_toggle   <= toggle_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tdata  = {1'b0, out_toggle, out_yaw, out_throttle, out_pitch, out_roll};

  a_one_frame_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(s1.valid && s2.valid))
    else $error("two frames in the map pipeline");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (rst)
    s2_stall |=> (s2.valid && $stable(s2)))
    else $error("stage two lost its frame during a stall");

  a_fire_loads_output: assert property (@(posedge clk) disable iff (rst)
    s2_fire |=> m_axis_tvalid)
    else $error("result not presented after leaving stage two");

endmodule
